// File: hw/rtl/tcgr_pkg.sv
// Shared types, constants and helper functions of the text cursor glyph rasterizer.
package tcgr_pkg;

	// Glyph geometry and magnification limits
	localparam int GLYPH_WIDTH  = 6;
	localparam int GLYPH_HEIGHT = 8;
	localparam int MAX_SCALE    = 4;

	// Font store and queue sizing
	localparam int STORE_DEPTH = 256 * GLYPH_WIDTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int QUEUE_DEPTH = 4;

	// Counter widths for the column sequencer
	localparam int COL_W = $clog2(GLYPH_WIDTH + 1);
	localparam int REP_W = $clog2(MAX_SCALE + 1);

	// Stream payload widths
	localparam int COLUMN_W   = GLYPH_HEIGHT * MAX_SCALE;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 80;

	typedef enum logic [2:0] {
		CMD_LOAD    = 3'd0,
		CMD_SET     = 3'd1,
		CMD_SAVE    = 3'd2,
		CMD_RESTORE = 3'd3,
		CMD_PUT     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_FILL   = 2'd0,
		KIND_WINDOW = 2'd1,
		KIND_COLUMN = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_ORIGIN_X = 3'd0,
		CFG_ORIGIN_Y = 3'd1,
		CFG_END_X    = 3'd2,
		CFG_END_Y    = 3'd3,
		CFG_SCALE    = 3'd4,
		CFG_ROTATE   = 3'd5,
		CFG_FG_COLOR = 3'd6,
		CFG_BG_COLOR = 3'd7
	} cfg_idx_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_PUT  = 1'b1
	} job_op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FILL,
		BK_WIN,
		BK_COL
	} bk_state_t;

	// Live configuration; scale is already clamped to 1..MAX_SCALE
	typedef struct packed {
		logic [7:0]  origin_x;
		logic [7:0]  origin_y;
		logic [7:0]  end_x;
		logic [7:0]  end_y;
		logic [2:0]  scale;
		logic        rotate;
		logic [15:0] bg_color;
	} cfg_t;

	// One unit of work handed from the front to the back
	typedef struct packed {
		job_op_t     op;
		logic        fill;
		logic [7:0]  ch;
		logic [2:0]  gcol;
		logic [7:0]  gbyte;
		logic [7:0]  fill_y0;
		logic [7:0]  fill_y1;
		logic [7:0]  win_x0;
		logic [7:0]  win_y0;
		logic [7:0]  win_x1;
		logic [7:0]  win_y1;
	} job_t;

	// One result item held in the output register
	typedef struct packed {
		kind_t               kind;
		logic [7:0]          x_start;
		logic [7:0]          y_start;
		logic [7:0]          x_stop;
		logic [7:0]          y_stop;
		logic [15:0]         fill_color;
		logic [COLUMN_W-1:0] column_bits;
		logic                last;
	} res_t;

	// Clamp the written scale: zero acts as one, large values as MAX_SCALE
	function automatic logic [2:0] eff_scale(logic [2:0] s);
		if (s == 3'd0) begin
			return 3'd1;
		end
		if (int'(s) > MAX_SCALE) begin
			return 3'(MAX_SCALE);
		end
		return s;
	endfunction

	// Repeat every glyph bit s times, top pixel in bit 0
	function automatic logic [COLUMN_W-1:0] widen(logic [7:0] b, logic [2:0] s);
		logic [COLUMN_W-1:0] v;
		v = '0;
		for (int k = 0; k < GLYPH_HEIGHT; k++) begin
			for (int r = 0; r < MAX_SCALE; r++) begin
				if (b[k] && r < int'(s) && (k * int'(s) + r) < COLUMN_W) begin
					v[k * int'(s) + r] = 1'b1;
				end
			end
		end
		return v;
	endfunction

endpackage

// File: hw/rtl/tcgr_front.sv
// Command front end: decodes requests, keeps the cursor and queues work for the back end.
module tcgr_front import tcgr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           in_cmd,
	input  logic [IN_DATA_W-1:0] in_data,
	input  logic                 q_full,
	output logic                 push,
	output job_t                 push_job
);

	logic [7:0]  cur_x_q, cur_y_q, sav_x_q, sav_y_q;
	logic [7:0]  cur_x_d, cur_y_d, sav_x_d, sav_y_d;
	logic [7:0]  ch, gbyte, tcol, trow;
	logic [2:0]  gcol;
	cmd_t        cmd;
	logic        accept;
	logic [7:0]  w8, h8;
	logic [15:0] prod_x, prod_y;
	logic [7:0]  set_x, set_y;
	logic [7:0]  ex0, ey_nowrap, cy_down, ey_down, ey_top, ex_wrap;
	logic        wrap, wrap_top;
	logic [7:0]  px, py, pex, pey;

	// Unpack the request fields
	assign ch     = in_data[7:0];
	assign gcol   = in_data[10:8];
	assign gbyte  = in_data[18:11];
	assign tcol   = in_data[26:19];
	assign trow   = in_data[34:27];
	assign cmd    = cmd_t'(in_cmd);

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	// Glyph cell size in pixels, modulo 256
	assign w8 = 8'(GLYPH_WIDTH * int'(cfg.scale));
	assign h8 = 8'(GLYPH_HEIGHT * int'(cfg.scale));

	// Set cursor: text position to pixels, fall back to origin past the end
	always_comb begin
		prod_x = tcol * {8'd0, w8};
		prod_y = trow * {8'd0, h8};
		set_x  = cfg.origin_x + prod_x[7:0];
		set_y  = cfg.origin_y + prod_y[7:0];
		if (set_x > cfg.end_x) begin
			set_x = cfg.origin_x;
		end
		if (set_y > cfg.end_y) begin
			set_y = cfg.origin_y;
		end
	end

	// Put char: line wrap check and window corners
	always_comb begin
		ex0       = cur_x_q + w8;
		ey_nowrap = cur_y_q + h8;
		cy_down   = cur_y_q + h8;
		ey_down   = cur_y_q + {h8[6:0], 1'b0};
		ey_top    = cfg.origin_y + h8;
		ex_wrap   = cfg.origin_x + w8;
		wrap      = ex0 > cfg.end_x;
		wrap_top  = ey_down > cfg.end_y;
		if (wrap) begin
			px  = cfg.origin_x;
			pex = ex_wrap;
			py  = wrap_top ? cfg.origin_y : cy_down;
			pey = wrap_top ? ey_top : ey_down;
		end else begin
			px  = cur_x_q;
			pex = ex0;
			py  = cur_y_q;
			pey = ey_nowrap;
		end
	end

	// Build the queued job and the next cursor state
	always_comb begin
		cur_x_d          = cur_x_q;
		cur_y_d          = cur_y_q;
		sav_x_d          = sav_x_q;
		sav_y_d          = sav_y_q;
		push             = 1'b0;
		push_job.op      = (cmd == CMD_PUT) ? OP_PUT : OP_LOAD;
		push_job.fill    = wrap;
		push_job.ch      = ch;
		push_job.gcol    = gcol;
		push_job.gbyte   = gbyte;
		push_job.fill_y0 = py;
		push_job.fill_y1 = pey;
		push_job.win_x0  = cfg.rotate ? py : px;
		push_job.win_y0  = cfg.rotate ? px : py;
		push_job.win_x1  = cfg.rotate ? pey : pex;
		push_job.win_y1  = cfg.rotate ? pex : pey;
		if (accept) begin
			unique case (cmd)
				CMD_LOAD: begin
					push = int'(gcol) < GLYPH_WIDTH;
				end
				CMD_SET: begin
					cur_x_d = set_x;
					cur_y_d = set_y;
				end
				CMD_SAVE: begin
					sav_x_d = cur_x_q;
					sav_y_d = cur_y_q;
				end
				CMD_RESTORE: begin
					cur_x_d = sav_x_q;
					cur_y_d = sav_y_q;
				end
				CMD_PUT: begin
					push    = 1'b1;
					cur_x_d = pex;
					cur_y_d = py;
				end
				default: begin
					push = 1'b0;
				end
			endcase
		end
	end

	// Hold cursor and saved cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			sav_x_q <= '0;
			sav_y_q <= '0;
		end else begin
			cur_x_q <= cur_x_d;
			cur_y_q <= cur_y_d;
			sav_x_q <= sav_x_d;
			sav_y_q <= sav_y_d;
		end
	end

endmodule

// File: hw/rtl/tcgr_queue.sv
// Short job queue between the command front end and the raster back end.
module tcgr_queue import tcgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue occupancy lost a push");

endmodule

// File: hw/rtl/tcgr_back.sv
// Raster back end: font store, fill and window results, scaled glyph columns.
module tcgr_back import tcgr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  job_t head,
	input  logic q_empty,
	output logic pop,
	output res_t res,
	output logic res_valid,
	input  logic res_ready
);

	bk_state_t        state_q, state_d;
	job_t             job_q;
	logic [COL_W-1:0] col_q;
	logic [REP_W-1:0] rep_q;
	logic [ADDR_W-1:0] base_q;
	logic [7:0]       glyph_mem [STORE_DEPTH];
	logic [7:0]       rd_data_q;
	res_t             out_q;
	res_t             out_d;
	logic             out_valid_q;

	logic             out_adv, emit, rep_last, col_last, take;
	logic             wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr, head_base;
	bk_state_t        start_state;

	assign head_base   = ADDR_W'(int'(head.ch) * GLYPH_WIDTH);
	assign start_state = (head.op == OP_LOAD) ? BK_IDLE : (head.fill ? BK_FILL : BK_WIN);
	assign out_adv     = !out_valid_q || res_ready;
	assign rep_last    = (rep_q == REP_W'(cfg.scale - 3'd1));
	assign col_last    = (col_q == COL_W'(GLYPH_WIDTH - 1)) && rep_last;

	// Sequencer control and font store access
	always_comb begin
		emit    = out_adv && (state_q != BK_IDLE);
		take    = (state_q == BK_IDLE) || (emit && state_q == BK_COL && col_last);
		pop     = take && !q_empty;
		wr_en   = pop && head.op == OP_LOAD;
		wr_addr = head_base + ADDR_W'(head.gcol);
		rd_en   = 1'b0;
		rd_addr = head_base;
		if (pop && head.op == OP_PUT) begin
			rd_en = 1'b1;
		end else if (emit && state_q == BK_COL && rep_last && !col_last) begin
			rd_en   = 1'b1;
			rd_addr = base_q + ADDR_W'(col_q) + 1'b1;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					state_d = start_state;
				end
			end
			BK_FILL: begin
				if (out_adv) begin
					state_d = BK_WIN;
				end
			end
			BK_WIN: begin
				if (out_adv) begin
					state_d = BK_COL;
				end
			end
			BK_COL: begin
				if (out_adv && col_last) begin
					state_d = pop ? start_state : BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Font store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			glyph_mem[wr_addr] <= head.gbyte;
		end
		if (rd_en) begin
			rd_data_q <= glyph_mem[rd_addr];
		end
	end

	// Latch the job being drawn
	always_ff @(posedge clk) begin
		if (pop && head.op == OP_PUT) begin
			job_q  <= head;
			base_q <= head_base;
		end
	end

	// Build the next result item
	always_comb begin
		out_d = '0;
		unique case (state_q)
			BK_FILL: begin
				out_d.kind       = KIND_FILL;
				out_d.x_start    = cfg.origin_x;
				out_d.y_start    = job_q.fill_y0;
				out_d.x_stop     = cfg.end_x;
				out_d.y_stop     = job_q.fill_y1;
				out_d.fill_color = cfg.bg_color;
			end
			BK_WIN: begin
				out_d.kind    = KIND_WINDOW;
				out_d.x_start = job_q.win_x0;
				out_d.y_start = job_q.win_y0;
				out_d.x_stop  = job_q.win_x1;
				out_d.y_stop  = job_q.win_y1;
			end
			default: begin
				out_d.kind        = KIND_COLUMN;
				out_d.column_bits = widen(rd_data_q, cfg.scale);
				out_d.last        = col_last;
			end
		endcase
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= out_d;
		end
	end

	// State, column counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			col_q       <= '0;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && head.op == OP_PUT) begin
				col_q <= '0;
				rep_q <= '0;
			end else if (emit && state_q == BK_COL && !col_last) begin
				if (rep_last) begin
					rep_q <= '0;
					col_q <= col_q + 1'b1;
				end else begin
					rep_q <= rep_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res       = out_q;
	assign res_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) !(rd_en && wr_en))
		else $error("font store read and written in one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_COL |-> (int'(col_q) < GLYPH_WIDTH && rep_q < REP_W'(cfg.scale)))
		else $error("column counters out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> out_q.kind == KIND_COLUMN)
		else $error("last flag on a non-column result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> job_q.op == OP_PUT)
		else $error("drawing a job that is not a put char");

endmodule

// File: hw/rtl/text_cursor_glyph_rasterizer.sv
// Top level of the text cursor glyph rasterizer: config registers and stream ports.
//
// Usage:
//   s_axis carries one command per request: tuser holds the command code, tdata the
//   character, glyph column, glyph byte and text position. Glyph loads, cursor set,
//   save and restore produce no output; put char produces an optional band fill
//   (when the line wraps), an address window, then GLYPH_WIDTH*scale pixel columns,
//   the final one flagged by tlast. m_axis tuser gives the result kind.
//   cfg writes one register per request and is always ready; write it only while
//   the block is idle.
// Timing:
//   Cursor commands finish in the front and are not queued. Glyph loads and put chars
//   reach the back end through a four-entry queue; a put char passes the queue, the job
//   register and the output register of the back end before it shows on m_axis. It then
//   issues 1 + GLYPH_WIDTH*scale results (one more with a band fill), one per cycle from
//   the single output register while m_axis is ready, and the next queued put char
//   follows without a gap. A glyph load is written into the font store when it is popped.
// Reset clears config to defaults, cursor and saved cursor to zero, and empties the
// queue; the font store is not cleared. When m_axis stalls, the output register holds,
// the back end stops, and s_axis drops tready once the queue is full.
module text_cursor_glyph_rasterizer import tcgr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [7:0] char_code, [10:8] glyph_column, [18:11] glyph_byte,
	// [26:19] text_col, [34:27] text_row, [39:35] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [2:0] command
	input  logic [2:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] x_start, [15:8] y_start, [23:16] x_stop, [31:24] y_stop,
	// [47:32] fill_color, [79:48] column_bits
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// [1:0] kind
	output logic [1:0]            m_axis_tuser,
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);

	logic [7:0]  origin_x_q, origin_y_q, end_x_q, end_y_q;
	logic [2:0]  scale_q;
	logic        rotate_q;
	logic [15:0] bg_color_q;
	cfg_t        cfg;
	logic        push, pop, q_empty, q_full;
	job_t        push_job, head;
	res_t        res;

	assign cfg_ready = 1'b1;

	// Configuration registers; foreground color has no effect on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= 8'd0;
			origin_y_q <= 8'd0;
			end_x_q    <= 8'd127;
			end_y_q    <= 8'd159;
			scale_q    <= 3'd1;
			rotate_q   <= 1'b0;
			bg_color_q <= 16'd0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ORIGIN_X: origin_x_q <= cfg_data[7:0];
				CFG_ORIGIN_Y: origin_y_q <= cfg_data[7:0];
				CFG_END_X:    end_x_q    <= cfg_data[7:0];
				CFG_END_Y:    end_y_q    <= cfg_data[7:0];
				CFG_SCALE:    scale_q    <= cfg_data[2:0];
				CFG_ROTATE:   rotate_q   <= cfg_data[0];
				CFG_FG_COLOR: bg_color_q <= bg_color_q;
				CFG_BG_COLOR: bg_color_q <= cfg_data;
				default:      bg_color_q <= bg_color_q;
			endcase
		end
	end

	// Live configuration view
	assign cfg.origin_x = origin_x_q;
	assign cfg.origin_y = origin_y_q;
	assign cfg.end_x    = end_x_q;
	assign cfg.end_y    = end_y_q;
	assign cfg.scale    = eff_scale(scale_q);
	assign cfg.rotate   = rotate_q;
	assign cfg.bg_color = bg_color_q;

	tcgr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_data  (s_axis_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	tcgr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	tcgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.res       (res),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready)
	);

	// Pack the result item onto the master stream
	assign m_axis_tdata = {res.column_bits, res.fill_color, res.y_stop, res.x_stop,
		res.y_start, res.x_start};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

// File: bench/text_cursor_glyph_rasterizer_tb.sv
// Self-checking testbench for the text cursor glyph rasterizer: command stream against a shadow console.
module text_cursor_glyph_rasterizer_tb;
	import tcgr_pkg::*;

	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 40;

	typedef enum logic [1:0] {
		ENT_CMD,
		ENT_REG,
		ENT_DRAIN,
		ENT_HOLD
	} entry_kind_e;

	// One entry of the stimulus backlog: a command request, a register write or a marker
	typedef struct {
		entry_kind_e what;
		logic [2:0]  cmd;
		logic [7:0]  ch;
		logic [2:0]  gcol;
		logic [7:0]  gbyte;
		logic [7:0]  tcol;
		logic [7:0]  trow;
		cfg_idx_t    reg_idx;
		logic [15:0] reg_val;
		int          gap;
	} console_req_t;

	// One drawing result the console owes
	typedef struct packed {
		kind_t               kind;
		logic [7:0]          x0;
		logic [7:0]          y0;
		logic [7:0]          x1;
		logic [7:0]          y1;
		logic [15:0]         color;
		logic [COLUMN_W-1:0] bits;
		logic                last;
	} draw_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [7:0] char_code, [10:8] glyph_column, [18:11] glyph_byte,
	// [26:19] text_col, [34:27] text_row, [39:35] zero
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// [2:0] command
	logic [2:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [7:0] x_start, [15:8] y_start, [23:16] x_stop, [31:24] y_stop,
	// [47:32] fill_color, [79:48] column_bits
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// [1:0] kind
	logic [1:0]            m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [2:0]            cfg_index = '0;
	logic [15:0]           cfg_data = '0;

	text_cursor_glyph_rasterizer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Shadow registers, cursor and font store of the console
	logic [7:0]  reg_org_x = 8'd0;
	logic [7:0]  reg_org_y = 8'd0;
	logic [7:0]  reg_end_x = 8'd127;
	logic [7:0]  reg_end_y = 8'd159;
	logic [2:0]  reg_scale = 3'd1;
	logic        reg_rotate = 1'b0;
	logic [15:0] reg_fg = 16'hFFFF;
	logic [15:0] reg_bg = 16'h0000;
	logic [7:0]  pen_x = 8'd0;
	logic [7:0]  pen_y = 8'd0;
	logic [7:0]  mark_x = 8'd0;
	logic [7:0]  mark_y = 8'd0;
	logic [7:0]  font_mem [STORE_DEPTH];

	console_req_t cmd_backlog[$];
	draw_t        owed_draws[$];
	int           mismatches = 0;

	// Stimulus bookkeeping: which glyphs are fully loaded and may be drawn
	logic [GLYPH_WIDTH-1:0] glyph_cols [256];
	bit                     glyph_usable [256];
	logic [7:0]             usable_chars[$];
	bit                     tx_calm = 1'b0;

	// Driver and monitor state
	console_req_t active_cmd;
	console_req_t head;
	int           gap_left = 0;
	int           quiet_run = 0;
	bit           in_busy;
	bit           reg_busy;
	logic         kick;
	logic         hold_kick = 1'b0;
	int           hold_left = 0;
	int           stall_left = 0;
	int           draws_seen = 0;
	draw_t        want;
	bit           ok;

	function automatic void queue_draw(kind_t k, logic [7:0] xs, logic [7:0] ys,
			logic [7:0] xe, logic [7:0] ye, logic [15:0] color,
			logic [COLUMN_W-1:0] bits, logic last);
		draw_t d;
		d.kind  = k;
		d.x0    = xs;
		d.y0    = ys;
		d.x1    = xe;
		d.y1    = ye;
		d.color = color;
		d.bits  = bits;
		d.last  = last;
		owed_draws.push_back(d);
	endfunction

	// Repeat each glyph bit s times, top pixel in bit 0
	function automatic logic [COLUMN_W-1:0] stretch_column(logic [7:0] b, int s);
		logic [COLUMN_W-1:0] v;
		v = '0;
		for (int k = 0; k < GLYPH_HEIGHT; k++) begin
			if (b[k]) begin
				for (int r = 0; r < s; r++) begin
					v[k * s + r] = 1'b1;
				end
			end
		end
		return v;
	endfunction

	function automatic void write_shadow(logic [2:0] idx, logic [15:0] data);
		case (cfg_idx_t'(idx))
			CFG_ORIGIN_X: reg_org_x = data[7:0];
			CFG_ORIGIN_Y: reg_org_y = data[7:0];
			CFG_END_X:    reg_end_x = data[7:0];
			CFG_END_Y:    reg_end_y = data[7:0];
			CFG_SCALE:    reg_scale = data[2:0];
			CFG_ROTATE:   reg_rotate = data[0];
			CFG_FG_COLOR: reg_fg = data;
			CFG_BG_COLOR: reg_bg = data;
			default: ;
		endcase
	endfunction

	// Apply one accepted command to the shadow console and queue the draws it owes
	function automatic void rasterize_cmd(console_req_t it);
		int s;
		int w;
		int h;
		logic [7:0] ex;
		logic [7:0] ey;
		logic [COLUMN_W-1:0] bits;
		s = (reg_scale == 3'd0) ? 1 : ((int'(reg_scale) > MAX_SCALE) ? MAX_SCALE : int'(reg_scale));
		w = GLYPH_WIDTH * s;
		h = GLYPH_HEIGHT * s;
		case (it.cmd)
			CMD_LOAD: begin
				if (int'(it.gcol) < GLYPH_WIDTH) begin
					font_mem[int'(it.ch) * GLYPH_WIDTH + int'(it.gcol)] = it.gbyte;
				end
			end
			CMD_SET: begin
				pen_x = 8'(reg_org_x + it.tcol * w);
				pen_y = 8'(reg_org_y + it.trow * h);
				if (pen_x > reg_end_x) begin
					pen_x = reg_org_x;
				end
				if (pen_y > reg_end_y) begin
					pen_y = reg_org_y;
				end
			end
			CMD_SAVE: begin
				mark_x = pen_x;
				mark_y = pen_y;
			end
			CMD_RESTORE: begin
				pen_x = mark_x;
				pen_y = mark_y;
			end
			CMD_PUT: begin
				ex = 8'(pen_x + w);
				ey = 8'(pen_y + h);
				// Wrap to a new line, or to the top line, and clear the band
				if (ex > reg_end_x) begin
					pen_x = reg_org_x;
					ex = 8'(pen_x + w);
					pen_y = 8'(pen_y + h);
					ey = 8'(pen_y + h);
					if (ey > reg_end_y) begin
						pen_y = reg_org_y;
						ey = 8'(pen_y + h);
					end
					queue_draw(KIND_FILL, reg_org_x, pen_y, reg_end_x, ey, reg_bg, '0, 1'b0);
				end
				if (reg_rotate) begin
					queue_draw(KIND_WINDOW, pen_y, pen_x, ey, ex, '0, '0, 1'b0);
				end else begin
					queue_draw(KIND_WINDOW, pen_x, pen_y, ex, ey, '0, '0, 1'b0);
				end
				for (int i = 0; i < GLYPH_WIDTH; i++) begin
					bits = stretch_column(font_mem[int'(it.ch) * GLYPH_WIDTH + i], s);
					for (int r = 0; r < s; r++) begin
						queue_draw(KIND_COLUMN, '0, '0, '0, '0, '0, bits,
							(i == GLYPH_WIDTH - 1) && (r == s - 1));
					end
				end
				pen_x = ex;
			end
			default: ;
		endcase
	endfunction

	function automatic bit field_ok(string name, logic [31:0] exp_val, logic [31:0] got);
		if (got !== exp_val) begin
			$error("%s expected 0x%0h, got 0x%0h", name, exp_val, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Stimulus builders
	function automatic console_req_t fresh_cmd(logic [2:0] code);
		console_req_t r;
		r.what    = ENT_CMD;
		r.cmd     = code;
		r.ch      = 8'($urandom);
		r.gcol    = 3'($urandom);
		r.gbyte   = 8'($urandom);
		r.tcol    = 8'($urandom);
		r.trow    = 8'($urandom);
		r.reg_idx = CFG_ORIGIN_X;
		r.reg_val = '0;
		r.gap     = tx_calm ? 0 : int'($urandom_range(0, 19));
		return r;
	endfunction

	function automatic void push_load(logic [7:0] ch, logic [2:0] col, logic [7:0] b);
		console_req_t r;
		r = fresh_cmd(CMD_LOAD);
		r.ch    = ch;
		r.gcol  = col;
		r.gbyte = b;
		cmd_backlog.push_back(r);
		if (int'(col) < GLYPH_WIDTH) begin
			glyph_cols[ch][col] = 1'b1;
			if (&glyph_cols[ch] && !glyph_usable[ch]) begin
				glyph_usable[ch] = 1'b1;
				usable_chars.push_back(ch);
			end
		end
	endfunction

	function automatic void push_put(logic [7:0] ch);
		console_req_t r;
		r = fresh_cmd(CMD_PUT);
		r.ch = ch;
		cmd_backlog.push_back(r);
	endfunction

	function automatic void push_set(logic [7:0] col, logic [7:0] row);
		console_req_t r;
		r = fresh_cmd(CMD_SET);
		r.tcol = col;
		r.trow = row;
		cmd_backlog.push_back(r);
	endfunction

	function automatic void push_plain(logic [2:0] code);
		cmd_backlog.push_back(fresh_cmd(code));
	endfunction

	function automatic void push_marker(entry_kind_e what);
		console_req_t r;
		r = fresh_cmd(CMD_SAVE);
		r.what = what;
		r.gap  = 0;
		cmd_backlog.push_back(r);
	endfunction

	function automatic void push_reg(cfg_idx_t idx, logic [15:0] val);
		console_req_t r;
		r = fresh_cmd(CMD_SAVE);
		r.what    = ENT_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		r.gap     = 0;
		cmd_backlog.push_back(r);
	endfunction

	function automatic void push_settings(logic [7:0] ox, logic [7:0] oy, logic [7:0] xe,
			logic [7:0] ye, logic [2:0] sc, logic rot, logic [15:0] fg, logic [15:0] bg);
		push_reg(CFG_ORIGIN_X, {8'd0, ox});
		push_reg(CFG_ORIGIN_Y, {8'd0, oy});
		push_reg(CFG_END_X, {8'd0, xe});
		push_reg(CFG_END_Y, {8'd0, ye});
		push_reg(CFG_SCALE, {13'd0, sc});
		push_reg(CFG_ROTATE, {15'd0, rot});
		push_reg(CFG_FG_COLOR, fg);
		push_reg(CFG_BG_COLOR, bg);
	endfunction

	function automatic logic [7:0] pick_glyph();
		return usable_chars[$urandom_range(0, usable_chars.size() - 1)];
	endfunction

	// Mostly well-formed console traffic: puts of loaded glyphs, whole glyph loads, cursor moves
	function automatic int push_random();
		int roll;
		logic [7:0] ch;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			push_put(pick_glyph());
			return 1;
		end
		if (roll < 53) begin
			ch = 8'($urandom);
			for (int c = 0; c < GLYPH_WIDTH; c++) begin
				push_load(ch, 3'(c), 8'($urandom));
			end
			return GLYPH_WIDTH;
		end
		if (roll < 66) begin
			push_load(8'($urandom), 3'($urandom), 8'($urandom));
			return 1;
		end
		if (roll < 80) begin
			if ($urandom_range(0, 3) != 0) begin
				push_set(8'($urandom_range(0, 24)), 8'($urandom_range(0, 20)));
			end else begin
				push_set(8'($urandom), 8'($urandom));
			end
			return 1;
		end
		if (roll < 87) begin
			push_plain(CMD_SAVE);
			return 1;
		end
		if (roll < 94) begin
			push_plain(CMD_RESTORE);
			return 1;
		end
		push_plain(3'(CMD_PUT) + 3'($urandom_range(1, 3)));
		return 1;
	endfunction

	function automatic void push_phase(int n);
		int made;
		made = 0;
		while (made < n) begin
			if (made % 10 == 0) begin
				tx_calm = ($urandom_range(0, 3) == 0);
			end
			made += push_random();
		end
	endfunction

	// Hold the receiver off for a long stretch when kicked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_kick) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Drive command and register requests from the backlog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= CFG_ORIGIN_X;
			cfg_data <= '0;
			hold_kick <= 1'b0;
			gap_left = 0;
			quiet_run = 0;
		end else begin
			in_busy = s_axis_tvalid;
			reg_busy = cfg_valid;
			kick = 1'b0;
			if (s_axis_tvalid && s_axis_tready) begin
				rasterize_cmd(active_cmd);
				in_busy = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				write_shadow(cfg_index, cfg_data);
				reg_busy = 1'b0;
			end
			// Count idle cycles so that queued loads finish before a register write
			if (owed_draws.size() == 0 && !in_busy) begin
				quiet_run++;
			end else begin
				quiet_run = 0;
			end
			if (!in_busy && !reg_busy && cmd_backlog.size() != 0) begin
				if (gap_left != 0) begin
					gap_left--;
				end else begin
					head = cmd_backlog[0];
					case (head.what)
						ENT_CMD: begin
							void'(cmd_backlog.pop_front());
							active_cmd = head;
							s_axis_tdata <= {5'd0, head.trow, head.tcol, head.gbyte, head.gcol, head.ch};
							s_axis_tuser <= head.cmd;
							in_busy = 1'b1;
							gap_left = head.gap;
						end
						ENT_HOLD: begin
							void'(cmd_backlog.pop_front());
							kick = 1'b1;
						end
						default: begin
							if (quiet_run >= SETTLE_CYCLES) begin
								void'(cmd_backlog.pop_front());
								if (head.what == ENT_REG) begin
									cfg_index <= head.reg_idx;
									cfg_data <= head.reg_val;
									reg_busy = 1'b1;
								end
							end
						end
					endcase
				end
			end
			s_axis_tvalid <= in_busy;
			cfg_valid <= reg_busy;
			hold_kick <= kick;
		end
	end

	// Accept results, compare against the oldest owed draw, then stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
			draws_seen = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_draws.size() == 0) begin
					$error("result with nothing owed: kind %0d", m_axis_tuser);
					mismatches++;
				end else begin
					want = owed_draws.pop_front();
					ok = field_ok("kind", 32'(want.kind), 32'(m_axis_tuser));
					ok = field_ok("x_start", 32'(want.x0), 32'(m_axis_tdata[7:0])) & ok;
					ok = field_ok("y_start", 32'(want.y0), 32'(m_axis_tdata[15:8])) & ok;
					ok = field_ok("x_stop", 32'(want.x1), 32'(m_axis_tdata[23:16])) & ok;
					ok = field_ok("y_stop", 32'(want.y1), 32'(m_axis_tdata[31:24])) & ok;
					ok = field_ok("fill_color", 32'(want.color), 32'(m_axis_tdata[47:32])) & ok;
					ok = field_ok("column_bits", want.bits, m_axis_tdata[79:48]) & ok;
					ok = field_ok("last", 32'(want.last), 32'(m_axis_tlast)) & ok;
					if (!ok) begin
						mismatches++;
					end
				end
				draws_seen++;
				stall_left = ((draws_seen / 96) % 3 == 1) ? 0 : int'($urandom_range(0, 19));
			end
			if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (hold_left == 0);
			end
		end
	end

	// Build the stimulus, release reset, wait for the console to drain
	initial begin
		for (int c = 0; c < 256; c++) begin
			glyph_cols[c] = '0;
			glyph_usable[c] = 1'b0;
		end

		// Directed: byte extremes in two glyphs, ignored columns, wrap to top, unknown codes
		push_load(8'h00, 3'd0, 8'h00);
		push_load(8'h00, 3'd1, 8'hFF);
		push_load(8'h00, 3'd2, 8'h01);
		push_load(8'h00, 3'd3, 8'h80);
		push_load(8'h00, 3'd4, 8'hAA);
		push_load(8'h00, 3'd5, 8'h55);
		push_load(8'hFF, 3'd0, 8'hFF);
		push_load(8'hFF, 3'd1, 8'h00);
		push_load(8'hFF, 3'd2, 8'h55);
		push_load(8'hFF, 3'd3, 8'hAA);
		push_load(8'hFF, 3'd4, 8'h80);
		push_load(8'hFF, 3'd5, 8'h01);
		push_load(8'hFF, 3'd6, 8'hFF);
		push_load(8'h00, 3'd7, 8'hFF);
		push_put(8'h00);
		push_put(8'hFF);
		push_plain(CMD_SAVE);
		push_set(8'hFF, 8'hFF);
		push_set(8'd20, 8'd18);
		push_put(8'h00);
		push_put(8'hFF);
		push_plain(CMD_RESTORE);
		push_put(8'h00);
		for (int u = 1; u <= 3; u++) begin
			push_plain(3'(CMD_PUT) + 3'(u));
		end

		// Default settings, with a long receiver hold while puts keep coming
		push_phase(PHASE_ITEMS / 2);
		push_marker(ENT_HOLD);
		tx_calm = 1'b1;
		for (int i = 0; i < 16; i++) begin
			push_put(pick_glyph());
		end
		push_marker(ENT_DRAIN);
		push_phase(PHASE_ITEMS / 2);

		// Full area, largest scale, rotated
		push_settings(8'd0, 8'd0, 8'd255, 8'd255, 3'd4, 1'b1, 16'h0000, 16'hFFFF);
		push_phase(PHASE_ITEMS);
		// Inverted area, zero scale
		push_settings(8'd255, 8'd255, 8'd0, 8'd0, 3'd0, 1'b0, 16'($urandom), 16'h0000);
		push_phase(PHASE_ITEMS);
		// Oversized scale
		push_settings(8'($urandom_range(0, 60)), 8'($urandom_range(0, 60)),
			8'($urandom_range(120, 255)), 8'($urandom_range(120, 255)), 3'd7, 1'b1,
			16'($urandom), 16'($urandom));
		push_phase(PHASE_ITEMS);
		push_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 3'd2, 1'b0,
			16'($urandom), 16'($urandom));
		push_phase(PHASE_ITEMS);
		push_settings(8'($urandom_range(0, 30)), 8'($urandom_range(0, 30)), 8'd255, 8'd255,
			3'd3, 1'b1, 16'($urandom), 16'($urandom));
		push_phase(PHASE_ITEMS);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || s_axis_tvalid || cfg_valid || owed_draws.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#2400000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
